// ===== design/dual_wheel_incremental_pid_assert.svh =====
// Assertion macros for the dual-wheel incremental PID controller.
// Expects clk and rst_n in the scope of every use.
`ifndef DUAL_WHEEL_INCREMENTAL_PID_ASSERT_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define DWIP_CHECK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define DWIP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dwip_pkg.sv =====
// Shared types and constants of the dual-wheel incremental PID controller.
// No dependencies.
`default_nettype none

package dwip_pkg;

  localparam int DRIVE_LIMIT = 512;
  localparam int SPEED_W     = 16;   // measured speed per wheel
  localparam int CFG_SPEED_W = 15;   // forward_speed / turn_rate registers
  localparam int GAIN_W      = 8;
  localparam int CFG_DATA_W  = 15;   // widest register
  localparam int CFG_IDX_W   = 3;
  localparam int TGT_W       = 16;   // forward +/- turn
  localparam int ERR_W       = 18;
  localparam int DIFF_W      = 20;   // e - 2*e1 + e2
  localparam int PROD_W      = 28;
  localparam int SUM_W       = 30;
  localparam int LEVEL_W     = 10;
  localparam int DUTY_W      = 10;

  localparam int IN_W          = 2 * SPEED_W;
  localparam int OUT_FIELDS_W  = 2 * (1 + DUTY_W) + 2 * LEVEL_W + 1;
  localparam int OUT_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_W - OUT_FIELDS_W;

  localparam logic signed [SUM_W-1:0]   SUM_HI   = SUM_W'(DRIVE_LIMIT - 1);
  localparam logic signed [SUM_W-1:0]   SUM_LO   = SUM_W'(-DRIVE_LIMIT);
  localparam logic signed [LEVEL_W-1:0] LEVEL_HI = LEVEL_W'(DRIVE_LIMIT - 1);
  localparam logic signed [LEVEL_W-1:0] LEVEL_LO = LEVEL_W'(-DRIVE_LIMIT);
  localparam logic [DUTY_W-1:0]         DUTY_FULL = DUTY_W'(DRIVE_LIMIT);

  localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(8);
  localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(4);
  localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORWARD_SPEED = 3'd0,
    REG_TURN_RATE     = 3'd1,
    REG_DRIVER_AWAKE  = 3'd2,
    REG_GAIN_P        = 3'd3,
    REG_GAIN_I        = 3'd4,
    REG_GAIN_D        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] p;
    logic [GAIN_W-1:0] i;
    logic [GAIN_W-1:0] d;
  } gains_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_term;
    logic signed [PROD_W-1:0] d_term;
  } prod_t;

  typedef struct packed {
    logic                      forward;
    logic [DUTY_W-1:0]         duty;
    logic signed [LEVEL_W-1:0] level;
  } wheel_out_t;

endpackage

`default_nettype wire

// ===== design/dwip_err_stage.sv =====
// Error stage of one wheel: error, its differences and the three gain products.
// Holds the last two errors of the wheel. Depends on dwip_pkg.
`default_nettype none

module dwip_err_stage
  import dwip_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     adv,
  input  wire logic signed [TGT_W-1:0]  target,
  input  wire logic signed [SPEED_W-1:0] measured,
  input  wire gains_t                   gains,
  output prod_t                         prod
);

  logic signed [ERR_W-1:0]  e1_r, e2_r, err;
  logic signed [DIFF_W-1:0] diff1, diff2;
  logic signed [PROD_W-1:0] d1_x, e_x, d2_x, gp_x, gi_x, gd_x;
  prod_t prod_r, prod_nxt;

  assign err   = ERR_W'(target) - ERR_W'(measured);
  assign diff1 = DIFF_W'(err) - DIFF_W'(e1_r);
  assign diff2 = DIFF_W'(err) - (DIFF_W'(e1_r) <<< 1) + DIFF_W'(e2_r);

  assign d1_x = PROD_W'(diff1);
  assign e_x  = PROD_W'(err);
  assign d2_x = PROD_W'(diff2);
  assign gp_x = PROD_W'($signed({1'b0, gains.p}));
  assign gi_x = PROD_W'($signed({1'b0, gains.i}));
  assign gd_x = PROD_W'($signed({1'b0, gains.d}));

  always_comb begin
    prod_nxt.p_term = d1_x * gp_x;
    prod_nxt.i_term = e_x * gi_x;
    prod_nxt.d_term = d2_x * gd_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r <= '0;
      e2_r <= '0;
    end else if (adv) begin
      e1_r <= err;
      e2_r <= e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== design/dwip_lvl_stage.sv =====
// Level stage of one wheel: accumulate, clamp, direction and duty.
// Holds the drive level, which is also the registered result. Depends on dwip_pkg.
`default_nettype none

module dwip_lvl_stage
  import dwip_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  adv,
  input  wire prod_t prod,
  output wheel_out_t wheel
);

  wheel_out_t wheel_r, wheel_nxt;
  logic signed [SUM_W-1:0]   sum;
  logic signed [LEVEL_W-1:0] lvl;

  assign sum = SUM_W'(wheel_r.level) + SUM_W'(prod.p_term)
             + SUM_W'(prod.i_term) + SUM_W'(prod.d_term);

  always_comb begin
    priority if (sum > SUM_HI) begin
      lvl = LEVEL_HI;
    end else if (sum < SUM_LO) begin
      lvl = LEVEL_LO;
    end else begin
      lvl = sum[LEVEL_W-1:0];
    end
  end

  // duty: limit minus level going forward, magnitude of level in reverse
  always_comb begin
    wheel_nxt.level   = lvl;
    wheel_nxt.forward = ~lvl[LEVEL_W-1];
    if (wheel_nxt.forward) begin
      wheel_nxt.duty = DUTY_FULL - DUTY_W'(lvl);
    end else begin
      wheel_nxt.duty = DUTY_W'(-lvl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_r.level   <= '0;
      wheel_r.forward <= 1'b1;
      wheel_r.duty    <= DUTY_FULL;
    end else if (adv) begin
      wheel_r <= wheel_nxt;
    end
  end

  assign wheel = wheel_r;

endmodule

`default_nettype wire

// ===== design/dual_wheel_incremental_pid.sv =====
// Throughput: one transaction per cycle while out_tready does not stall; input register, error/product
// register and result register form a three-deep pipeline, so up to three
// transactions are in flight and in_tready falls only when all three are held.
// Reset (rst_n low, synchronous): registers to defaults, errors and levels to 0, pipeline empty.
`default_nettype none
`include "dual_wheel_incremental_pid_assert.svh"

module dual_wheel_incremental_pid
  import dwip_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,   // left_speed, right_speed
  // result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // left_forward, left_duty, right_forward, right_duty, left_level,
  // right_level, driver_enable, zero pad
  output logic [OUT_W-1:0]           out_tdata,
  // configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [CFG_SPEED_W-1:0] forward_speed_r, turn_rate_r;
  logic                          driver_awake_r;
  gains_t                        gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_speed_r <= '0;
      turn_rate_r     <= '0;
      driver_awake_r  <= 1'b0;
      gains_r.p       <= GAIN_P_RST;
      gains_r.i       <= GAIN_I_RST;
      gains_r.d       <= GAIN_D_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FORWARD_SPEED: forward_speed_r <= cfg_wdata[CFG_SPEED_W-1:0];
        REG_TURN_RATE:     turn_rate_r     <= cfg_wdata[CFG_SPEED_W-1:0];
        REG_DRIVER_AWAKE:  driver_awake_r  <= cfg_wdata[0];
        REG_GAIN_P:        gains_r.p       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:        gains_r.i       <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:        gains_r.d       <= cfg_wdata[GAIN_W-1:0];
        default: ;  // unused indexes ignored
      endcase
    end
  end

  // Wheel targets; left gets +turn, right gets -turn
  logic signed [TGT_W-1:0] tgt_left, tgt_right;
  assign tgt_left  = TGT_W'(forward_speed_r) + TGT_W'(turn_rate_r);
  assign tgt_right = TGT_W'(forward_speed_r) - TGT_W'(turn_rate_r);

  // ---------------------------------------------------------------------
  // Pipeline control: each stage moves when the one after it has room
  // ---------------------------------------------------------------------
  logic s0_v_r, s0_v_nxt;
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_ready, s1_ready;
  logic adv0, adv1, adv2;

  assign out_ready = !out_v_r || out_tready;
  assign s1_ready  = !s1_v_r || out_ready;
  assign in_tready = !s0_v_r || s1_ready;

  assign adv0 = in_tvalid && in_tready;
  assign adv1 = s0_v_r && s1_ready;
  assign adv2 = s1_v_r && out_ready;

  assign s0_v_nxt  = adv0 || (s0_v_r && !adv1);
  assign s1_v_nxt  = adv1 || (s1_v_r && !adv2);
  assign out_v_nxt = adv2 || (out_v_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Input register
  logic signed [SPEED_W-1:0] left_speed_r, right_speed_r;

  always_ff @(posedge clk) begin
    if (adv0) begin
      left_speed_r  <= in_tdata[SPEED_W-1:0];
      right_speed_r <= in_tdata[IN_W-1:SPEED_W];
    end
  end

  // ---------------------------------------------------------------------
  // Per-wheel datapath: error stage, then level stage
  // ---------------------------------------------------------------------
  prod_t      prod_left, prod_right;
  wheel_out_t wheel_left, wheel_right;

  dwip_err_stage u_err_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv1),
    .target   (tgt_left),
    .measured (left_speed_r),
    .gains    (gains_r),
    .prod     (prod_left)
  );

  dwip_err_stage u_err_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv1),
    .target   (tgt_right),
    .measured (right_speed_r),
    .gains    (gains_r),
    .prod     (prod_right)
  );

  dwip_lvl_stage u_lvl_left (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv2),
    .prod  (prod_left),
    .wheel (wheel_left)
  );

  dwip_lvl_stage u_lvl_right (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv2),
    .prod  (prod_right),
    .wheel (wheel_right)
  );

  // driver enable travels with the result transaction
  logic driver_en_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      driver_en_r <= driver_awake_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, driver_en_r,
                       wheel_right.level, wheel_left.level,
                       wheel_right.duty, wheel_right.forward,
                       wheel_left.duty, wheel_left.forward};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `DWIP_CHECK_IMPL(a_ready_only_when_full, !in_tready, s0_v_r && s1_v_r && out_v_r,
                   "in_tready low with a free pipeline stage")

  `DWIP_CHECK_NEXT(a_stall_keeps_item, s0_v_r && !s1_ready, s0_v_r && s1_v_r,
                   "stalled transaction lost from the pipeline")

  `DWIP_CHECK_IMPL(a_dir_follows_sign, out_tvalid,
                   (wheel_left.forward != wheel_left.level[LEVEL_W-1]) &&
                   (wheel_right.forward != wheel_right.level[LEVEL_W-1]),
                   "direction bit disagrees with level sign")

  `DWIP_CHECK_IMPL(a_duty_in_range, out_tvalid,
                   (wheel_left.duty != '0) && (wheel_left.duty <= DUTY_FULL) &&
                   (wheel_right.duty != '0) && (wheel_right.duty <= DUTY_FULL),
                   "duty outside 1 to drive limit")

endmodule

`default_nettype wire
